[src/sqrs_pkg.sv]
// sqrs_pkg: types and constants shared by the quadratic root solver.
// Depends on nothing; every other file imports it.
package sqrs_pkg;

	localparam int DATA_W      = 32;
	localparam int DISC_W      = 2*DATA_W + 2;
	localparam int ROOT_W      = DATA_W + 1;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NEG_DISC = 2'd1,
		ST_ZERO_A   = 2'd2,
		ST_SAT      = 2'd3
	} sqrs_status_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] coef_square;
		logic signed [DATA_W-1:0] coef_linear;
		logic signed [DATA_W-1:0] coef_const;
	} sqrs_coef_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] root_first;
		logic signed [DATA_W-1:0] root_second;
		sqrs_status_t             status;
	} sqrs_root_t;

	typedef struct packed {
		sqrs_coef_t         coef;
		logic [DISC_W-1:0]  disc;
		sqrs_status_t       status;
	} sqrs_job_t;

endpackage

[src/sqrs_front.sv]
// sqrs_front: registers coefficients, forms b*b and a*c, then the discriminant
// and the early status. Depends on sqrs_pkg.
module sqrs_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  sqrs_pkg::sqrs_coef_t operands,
	output logic [1:0]         inflight,
	output logic               push,
	output sqrs_pkg::sqrs_job_t job
);
	import sqrs_pkg::*;

	logic                         v_s1, v_s2;
	sqrs_coef_t                   coef_s1, coef_s2;
	logic signed [2*DATA_W-1:0]   bsq_s2, ac_s2;
	logic [2*DATA_W+2:0]          disc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			coef_s1 <= operands;
		end
		coef_s2 <= coef_s1;
		bsq_s2  <= $signed(coef_s1.coef_linear) * $signed(coef_s1.coef_linear);
		ac_s2   <= $signed(coef_s1.coef_square) * $signed(coef_s1.coef_const);
	end

	always_comb begin
		disc = {{3{bsq_s2[2*DATA_W-1]}}, bsq_s2} - {ac_s2[2*DATA_W-1], ac_s2, 2'b00};
		job.coef = coef_s2;
		job.disc = disc[DISC_W-1:0];
		if (coef_s2.coef_square == '0) begin
			job.status = ST_ZERO_A;
		end else if (disc[2*DATA_W+2]) begin
			job.status = ST_NEG_DISC;
		end else begin
			job.status = ST_OK;
		end
	end

	assign push     = v_s2;
	assign inflight = {1'b0, v_s1} + {1'b0, v_s2};

endmodule

[src/sqrs_fifo.sv]
// sqrs_fifo: short queue of classified jobs between front and back.
// Depends on sqrs_pkg; drains one job per cycle whenever not empty.
module sqrs_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sqrs_pkg::sqrs_job_t wdata,
	output logic                rvld,
	output sqrs_pkg::sqrs_job_t rdata,
	output logic [sqrs_pkg::QPTR_W:0] level
);
	import sqrs_pkg::*;

	sqrs_job_t           mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_q, rd_q;
	logic [QPTR_W:0]     level_q;
	logic                pop;

	assign pop   = (level_q != '0);
	assign rvld  = pop;
	assign rdata = mem[rd_q];
	assign level = level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			level_q <= level_q + {{QPTR_W{1'b0}}, push} - {{QPTR_W{1'b0}}, pop};
		end
	end

endmodule

[src/sqrs_isqrt.sv]
// sqrs_isqrt: pipelined integer square root, one root bit per stage.
// Depends on sqrs_pkg for the radicand and root widths.
module sqrs_isqrt #(
	parameter int TAG_W = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_vld,
	input  logic [sqrs_pkg::DISC_W-1:0] in_rad,
	input  logic [TAG_W-1:0]            in_tag,
	output logic                        out_vld,
	output logic [sqrs_pkg::ROOT_W-1:0] out_root,
	output logic [TAG_W-1:0]            out_tag
);
	import sqrs_pkg::*;

	localparam int NSTG  = ROOT_W;
	localparam int REM_W = ROOT_W + 2;

	logic               vld_s [NSTG];
	logic [DISC_W-1:0]  rad_s [NSTG];
	logic [ROOT_W-1:0]  rt_s  [NSTG];
	logic [REM_W-1:0]   rm_s  [NSTG];
	logic [TAG_W-1:0]   tag_s [NSTG];

	for (genvar k = 0; k < NSTG; k++) begin : g_stg
		logic               v_i;
		logic [DISC_W-1:0]  x_i;
		logic [ROOT_W-1:0]  r_i;
		logic [REM_W-1:0]   m_i;
		logic [TAG_W-1:0]   t_i;
		logic [REM_W+1:0]   tmp, trial;
		logic               ge;

		if (k == 0) begin : g_in
			assign v_i = in_vld;
			assign x_i = in_rad;
			assign r_i = '0;
			assign m_i = '0;
			assign t_i = in_tag;
		end else begin : g_mid
			assign v_i = vld_s[k-1];
			assign x_i = rad_s[k-1];
			assign r_i = rt_s[k-1];
			assign m_i = rm_s[k-1];
			assign t_i = tag_s[k-1];
		end

		assign tmp   = {m_i, x_i[DISC_W-1 -: 2]};
		assign trial = {2'b00, r_i, 2'b01};
		assign ge    = (tmp >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			rad_s[k] <= x_i << 2;
			rt_s[k]  <= {r_i[ROOT_W-2:0], ge};
			rm_s[k]  <= ge ? REM_W'(tmp - trial) : tmp[REM_W-1:0];
			tag_s[k] <= t_i;
		end
	end

	assign out_vld  = vld_s[NSTG-1];
	assign out_root = rt_s[NSTG-1];
	assign out_tag  = tag_s[NSTG-1];

endmodule

[src/sqrs_div.sv]
// sqrs_div: pipelined restoring divider, one quotient bit per stage.
// Depends on sqrs_pkg only by convention; widths come from parameters.
module sqrs_div #(
	parameter int DVD_W = 16,
	parameter int DVS_W = 16,
	parameter int TAG_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  logic [DVD_W-1:0] in_dvd,
	input  logic [DVS_W-1:0] in_dvs,
	input  logic [TAG_W-1:0] in_tag,
	output logic             out_vld,
	output logic [DVD_W-1:0] out_quo,
	output logic [TAG_W-1:0] out_tag
);
	import sqrs_pkg::*;

	logic             vld_s [DVD_W];
	logic [DVD_W-1:0] qd_s  [DVD_W];
	logic [DVS_W-1:0] dvs_s [DVD_W];
	logic [DVS_W-1:0] rm_s  [DVD_W];
	logic [TAG_W-1:0] tag_s [DVD_W];

	for (genvar k = 0; k < DVD_W; k++) begin : g_stg
		logic             v_i;
		logic [DVD_W-1:0] q_i;
		logic [DVS_W-1:0] d_i;
		logic [DVS_W-1:0] m_i;
		logic [TAG_W-1:0] t_i;
		logic [DVS_W:0]   tmp;
		logic             ge;

		if (k == 0) begin : g_in
			assign v_i = in_vld;
			assign q_i = in_dvd;
			assign d_i = in_dvs;
			assign m_i = '0;
			assign t_i = in_tag;
		end else begin : g_mid
			assign v_i = vld_s[k-1];
			assign q_i = qd_s[k-1];
			assign d_i = dvs_s[k-1];
			assign m_i = rm_s[k-1];
			assign t_i = tag_s[k-1];
		end

		assign tmp = {m_i, q_i[DVD_W-1]};
		assign ge  = (tmp >= {1'b0, d_i});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			qd_s[k]  <= {q_i[DVD_W-2:0], ge};
			dvs_s[k] <= d_i;
			rm_s[k]  <= ge ? DVS_W'(tmp - {1'b0, d_i}) : tmp[DVS_W-1:0];
			tag_s[k] <= t_i;
		end
	end

	assign out_vld = vld_s[DVD_W-1];
	assign out_quo = qd_s[DVD_W-1];
	assign out_tag = tag_s[DVD_W-1];

endmodule

[src/sqrs_back.sv]
// sqrs_back: square root, first-root divide, product, second-root divide, clamp.
// Depends on sqrs_pkg, sqrs_isqrt and sqrs_div.
module sqrs_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  sqrs_pkg::sqrs_job_t  in_job,
	output logic                 done,
	output sqrs_pkg::sqrs_root_t result
);
	import sqrs_pkg::*;

	localparam int DW    = DATA_W;
	localparam int NUM_W = ROOT_W + 1;
	localparam int D1_W  = NUM_W + FRAC_BITS;
	localparam int D1S_W = DW + 1;
	localparam int D2_W  = DW + 2*FRAC_BITS;
	localparam int D2S_W = 2*DW;
	localparam int Q_W   = (D1_W > D2_W) ? D1_W : D2_W;

	typedef struct packed {
		sqrs_coef_t   coef;
		sqrs_status_t status;
	} sq_tag_t;

	typedef struct packed {
		logic signed [DW-1:0] a;
		logic signed [DW-1:0] c;
		sqrs_status_t         status;
		logic                 neg;
	} d1_tag_t;

	typedef struct packed {
		logic signed [DW-1:0] x1;
		logic                 sat1;
		logic                 neg;
		logic                 x1_zero;
		sqrs_status_t         status;
	} d2_tag_t;

	function automatic logic [DW:0] clamp(input logic [Q_W-1:0] m, input logic neg);
		logic [Q_W-1:0] lim;
		logic [Q_W-1:0] negm;
		lim  = Q_W'(1) << (DW-1);
		negm = ~m + Q_W'(1);
		if (neg) begin
			if (m > lim) begin
				return {1'b1, 1'b1, {(DW-1){1'b0}}};
			end
			return {1'b0, negm[DW-1:0]};
		end
		if (m > lim - Q_W'(1)) begin
			return {1'b1, 1'b0, {(DW-1){1'b1}}};
		end
		return {1'b0, m[DW-1:0]};
	endfunction

	sq_tag_t             sq_tag_in, sq_tag_out;
	logic                sq_vld;
	logic [ROOT_W-1:0]   sq_root;

	assign sq_tag_in.coef   = in_job.coef;
	assign sq_tag_in.status = in_job.status;

	sqrs_isqrt #(.TAG_W($bits(sq_tag_t))) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (in_vld),
		.in_rad   (in_job.disc),
		.in_tag   (sq_tag_in),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_tag  (sq_tag_out)
	);

	logic [DW-1:0]    abs_a, abs_b;
	logic [NUM_W-1:0] nmag;
	logic             v_s1;
	logic [NUM_W-1:0] nmag_s1;
	logic [D1S_W-1:0] dvs_s1;
	d1_tag_t          tag_s1;

	assign abs_a = sq_tag_out.coef.coef_square[DW-1] ?
		~sq_tag_out.coef.coef_square + 1'b1 : sq_tag_out.coef.coef_square;
	assign abs_b = sq_tag_out.coef.coef_linear[DW-1] ?
		~sq_tag_out.coef.coef_linear + 1'b1 : sq_tag_out.coef.coef_linear;
	assign nmag  = NUM_W'(abs_b) + NUM_W'(sq_root);

	always_ff @(posedge clk) begin
		nmag_s1       <= nmag;
		dvs_s1        <= {abs_a, 1'b0};
		tag_s1.a      <= sq_tag_out.coef.coef_square;
		tag_s1.c      <= sq_tag_out.coef.coef_const;
		tag_s1.status <= sq_tag_out.status;
		tag_s1.neg    <= (nmag != '0) &&
			(!sq_tag_out.coef.coef_linear[DW-1] != sq_tag_out.coef.coef_square[DW-1]);
	end

	logic            d1_vld;
	logic [D1_W-1:0] q1;
	d1_tag_t         d1_tag;

	sqrs_div #(.DVD_W(D1_W), .DVS_W(D1S_W), .TAG_W($bits(d1_tag_t))) u_div1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (v_s1),
		.in_dvd  (D1_W'(nmag_s1) << FRAC_BITS),
		.in_dvs  (dvs_s1),
		.in_tag  (tag_s1),
		.out_vld (d1_vld),
		.out_quo (q1),
		.out_tag (d1_tag)
	);

	logic                 v_s2, v_s3, v_s4, done_q;
	logic [DW:0]          cl1;
	logic signed [DW-1:0] x1_s2, a_s2, c_s2;
	logic                 sat1_s2;
	sqrs_status_t         st_s2;
	logic signed [DW-1:0] x1_s3, c_s3;
	logic                 sat1_s3;
	sqrs_status_t         st_s3;
	logic signed [2*DW-1:0] p_s3;
	logic [D2_W-1:0]      dvd_s4;
	logic [D2S_W-1:0]     dvs_s4;
	d2_tag_t              tag_s4;
	logic [DW-1:0]        abs_c;
	logic [2*DW-1:0]      abs_p;

	assign cl1   = clamp(Q_W'(q1), d1_tag.neg);
	assign abs_c = c_s3[DW-1] ? ~c_s3 + 1'b1 : c_s3;
	assign abs_p = p_s3[2*DW-1] ? ~p_s3 + 1'b1 : p_s3;

	always_ff @(posedge clk) begin
		x1_s2   <= cl1[DW-1:0];
		sat1_s2 <= cl1[DW];
		a_s2    <= d1_tag.a;
		c_s2    <= d1_tag.c;
		st_s2   <= d1_tag.status;

		p_s3    <= a_s2 * x1_s2;
		x1_s3   <= x1_s2;
		sat1_s3 <= sat1_s2;
		c_s3    <= c_s2;
		st_s3   <= st_s2;

		dvd_s4         <= D2_W'(abs_c) << (2*FRAC_BITS);
		dvs_s4         <= abs_p;
		tag_s4.x1      <= x1_s3;
		tag_s4.sat1    <= sat1_s3;
		tag_s4.neg     <= (abs_c != '0) && (c_s3[DW-1] != p_s3[2*DW-1]);
		tag_s4.x1_zero <= (x1_s3 == '0);
		tag_s4.status  <= st_s3;
	end

	logic            d2_vld;
	logic [D2_W-1:0] q2;
	d2_tag_t         d2_tag;

	sqrs_div #(.DVD_W(D2_W), .DVS_W(D2S_W), .TAG_W($bits(d2_tag_t))) u_div2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (v_s4),
		.in_dvd  (dvd_s4),
		.in_dvs  (dvs_s4),
		.in_tag  (tag_s4),
		.out_vld (d2_vld),
		.out_quo (q2),
		.out_tag (d2_tag)
	);

	logic [DW:0] cl2;
	sqrs_root_t  res_d, result_q;
	logic        sat;

	assign cl2 = clamp(Q_W'(q2), d2_tag.neg);

	always_comb begin
		res_d = '0;
		sat   = d2_tag.sat1 | (!d2_tag.x1_zero & cl2[DW]);
		if (d2_tag.status != ST_OK) begin
			res_d.status = d2_tag.status;
		end else begin
			res_d.root_first  = d2_tag.x1;
			res_d.root_second = d2_tag.x1_zero ? '0 : cl2[DW-1:0];
			res_d.status      = sat ? ST_SAT : ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= sq_vld;
			v_s2   <= d1_vld;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			done_q <= d2_vld;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

[src/stable_quadratic_root_solver.sv]
// stable_quadratic_root_solver: top level of the fixed-point quadratic solver.
// Depends on sqrs_pkg, sqrs_front, sqrs_fifo and sqrs_back.
//
// Usage:
//   Drive operands (a, b, c in signed fixed point) and raise start; the set is
//   taken on a clock edge where start is high and busy is low.
//   One result leaves per set: done pulses for one cycle with result valid.
//   The receiver cannot stall; results must be taken in the done cycle.
// Throughput: one set per cycle, sustained while busy is low.
// Pipeline, from the accepting edge to the edge that takes the result:
//   2 front stages, the queue register, DATA_W+1 square-root stages,
//   DATA_W+2+FRAC_BITS first-divide stages, DATA_W+2*FRAC_BITS second-divide
//   stages and five registers for sum, clamp, product, magnitude and output.
//   The two pipelined dividers make up most of the pipeline.
// The front hands classified jobs to a four-entry queue; the back drains
//   it every cycle, so busy only rises if the queue could overflow.
// Reset clears all valid bits and the queue; no result is produced until
//   a new set is taken.
module stable_quadratic_root_solver #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  sqrs_pkg::sqrs_coef_t operands,
	output logic                 done,
	output sqrs_pkg::sqrs_root_t result
);
	import sqrs_pkg::*;

	logic            accept, push, q_vld;
	logic [1:0]      inflight;
	logic [QPTR_W:0] level;
	sqrs_job_t       job, q_job;

	assign busy   = ({1'b0, level} + {{QPTR_W{1'b0}}, inflight})
		>= (QPTR_W+2)'(QUEUE_DEPTH);
	assign accept = start & ~busy;

	sqrs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.operands (operands),
		.inflight (inflight),
		.push     (push),
		.job      (job)
	);

	sqrs_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (job),
		.rvld   (q_vld),
		.rdata  (q_job),
		.level  (level)
	);

	sqrs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (q_vld),
		.in_job (q_job),
		.done   (done),
		.result (result)
	);

endmodule

[src/sqrs_chk.sv]
// sqrs_chk: port-level checks of the solver's result beats, bound to the top.
// Depends on sqrs_pkg and stable_quadratic_root_solver.
module sqrs_chk (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 done,
	input sqrs_pkg::sqrs_root_t result
);
	import sqrs_pkg::*;

	localparam logic [DATA_W-1:0] MAX_V = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] MIN_V = {1'b1, {(DATA_W-1){1'b0}}};

	a_neg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == ST_NEG_DISC) |->
		(result.root_first == '0) && (result.root_second == '0))
		else $error("negative discriminant beat carries nonzero roots");

	a_zero_a: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == ST_ZERO_A) |->
		(result.root_first == '0) && (result.root_second == '0))
		else $error("zero a beat carries nonzero roots");

	a_first_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == ST_OK) && (result.root_first == '0) |->
		(result.root_second == '0))
		else $error("zero first root with nonzero second root");

	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == ST_SAT) |->
		(result.root_first == MAX_V) || (result.root_first == MIN_V) ||
		(result.root_second == MAX_V) || (result.root_second == MIN_V))
		else $error("saturated beat without a root at a limit");

endmodule

bind stable_quadratic_root_solver sqrs_chk u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.done   (done),
	.result (result)
);

[tb/tb_stable_quadratic_root_solver.sv]
// tb_stable_quadratic_root_solver: self-checking bench for the fixed-point quadratic solver.
// Builds expected roots and status for every accepted coefficient set and checks each done beat.
// Depends on sqrs_pkg and stable_quadratic_root_solver.
module tb_stable_quadratic_root_solver;
	timeunit 1ns;
	timeprecision 1ps;
	import sqrs_pkg::*;

	localparam int FRAC_BITS = 16;
	localparam longint POS_LIM = 64'sd2147483647;
	localparam longint NEG_LIM = -64'sd2147483648;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	sqrs_coef_t operands;
	logic       done;
	sqrs_root_t result;

	sqrs_coef_t coef_sets[$];
	sqrs_root_t roots_due[$];
	int         gap_left;
	int         bad_count = 0;

	stable_quadratic_root_solver #(.FRAC_BITS(FRAC_BITS)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operands(operands), .done(done), .result(result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [71:0] floor_sqrt(logic [71:0] x);
		logic [71:0] res;
		logic [71:0] one;
		res = '0;
		one = 72'd1 << 70;
		while (one > x) one = one >> 2;
		while (one != 0) begin
			if (x >= res + one) begin
				x   = x - (res + one);
				res = (res >> 1) + one;
			end else begin
				res = res >> 1;
			end
			one = one >> 2;
		end
		return res;
	endfunction

	function automatic longint clamp_root(logic [127:0] m, bit neg, inout bit sat);
		if (neg) begin
			if (m > 128'd2147483648) begin
				sat = 1'b1;
				return NEG_LIM;
			end
			return -longint'(m[63:0]);
		end
		if (m > 128'd2147483647) begin
			sat = 1'b1;
			return POS_LIM;
		end
		return longint'(m[63:0]);
	endfunction

	function automatic sqrs_root_t solve_roots(sqrs_coef_t cf);
		sqrs_root_t         r;
		logic signed [71:0] a, b, c, disc;
		logic [71:0]        root_d, amag, bmag, cmag, nmag, pmag;
		logic [127:0]       q;
		longint             x1, x2, p;
		bit                 sat, nneg;
		a = cf.coef_square;
		b = cf.coef_linear;
		c = cf.coef_const;
		r.root_first  = '0;
		r.root_second = '0;
		r.status      = ST_OK;
		x1 = 0;
		x2 = 0;
		sat = 1'b0;
		if (a == 0) begin
			r.status = ST_ZERO_A;
			return r;
		end
		disc = b * b - 4 * a * c;
		if (disc < 0) begin
			r.status = ST_NEG_DISC;
			return r;
		end
		root_d = floor_sqrt(disc);
		amag = (a < 0) ? -a : a;
		bmag = (b < 0) ? -b : b;
		cmag = (c < 0) ? -c : c;
		nmag = bmag + root_d;
		nneg = (b >= 0);
		q = ({56'd0, nmag} << FRAC_BITS) / {56'd0, (amag << 1)};
		x1 = clamp_root(q, (nmag != 0) && (nneg != (a < 0)), sat);
		if (x1 != 0) begin
			p = longint'(a) * x1;
			pmag = (p < 0) ? -p : p;
			q = ({56'd0, cmag} << (2 * FRAC_BITS)) / {56'd0, pmag};
			x2 = clamp_root(q, (cmag != 0) && ((c < 0) != (p < 0)), sat);
		end
		r.root_first  = x1[31:0];
		r.root_second = x2[31:0];
		if (sat) r.status = ST_SAT;
		return r;
	endfunction

	function automatic logic [31:0] any_coef();
		return $signed($urandom) >>> $urandom_range(0, 31);
	endfunction

	function automatic int draw_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60) return 0;
		if (pick < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// feed coefficient sets and record the expected roots of each accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start    <= 1'b0;
			operands <= '0;
			gap_left <= 0;
		end else begin
			if (start && !busy) begin
				roots_due.push_back(solve_roots(operands));
				coef_sets.pop_front();
			end
			if (start && busy) begin
				start <= 1'b1;
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start    <= 1'b0;
			end else if (coef_sets.size() > 0) begin
				start    <= 1'b1;
				operands <= coef_sets[0];
				gap_left <= draw_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// check every done beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (roots_due.size() == 0) begin
				$display("%0t: unexpected result %h", $time, result);
				bad_count++;
			end else begin
				if (result.root_first !== roots_due[0].root_first ||
				    result.root_second !== roots_due[0].root_second ||
				    result.status !== roots_due[0].status) begin
					$display("%0t: expected %h %h %s, got %h %h %0d", $time,
						roots_due[0].root_first, roots_due[0].root_second,
						roots_due[0].status.name(), result.root_first,
						result.root_second, result.status);
					bad_count++;
				end
				roots_due.pop_front();
			end
		end
	end

	initial begin
		sqrs_coef_t cf;
		int         i;
		arst_n = 1'b0;
		// directed: zero a, negative discriminant, zero first root, extremes, saturation
		coef_sets.push_back('{32'sd0, 32'sd65536, 32'sd65536});
		coef_sets.push_back('{32'sd0, 32'h8000_0000, 32'h7fff_ffff});
		coef_sets.push_back('{32'sd65536, 32'sd0, 32'sd65536});
		coef_sets.push_back('{-32'sd65536, 32'sd0, -32'sd65536});
		coef_sets.push_back('{32'sd65536, 32'sd0, 32'sd0});
		coef_sets.push_back('{32'sd65536, 32'sd0, -32'sd262144});
		coef_sets.push_back('{32'sd65536, -32'sd196608, 32'sd131072});
		coef_sets.push_back('{32'sd65536, 32'sd196608, 32'sd131072});
		coef_sets.push_back('{-32'sd65536, 32'sd65536, 32'sd0});
		coef_sets.push_back('{32'sd1, 32'h7fff_ffff, 32'sd1});
		coef_sets.push_back('{32'sd1, 32'h8000_0000, 32'sd0});
		coef_sets.push_back('{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000});
		coef_sets.push_back('{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff});
		coef_sets.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
		coef_sets.push_back('{32'h7fff_ffff, 32'sd0, 32'h8000_0000});
		coef_sets.push_back('{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
		coef_sets.push_back('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
		coef_sets.push_back('{32'sd65536, 32'sd1, 32'h8000_0000});
		coef_sets.push_back('{32'sd3, -32'sd1, 32'h7fff_ffff});
		for (i = 0; i < 1130; i++) begin
			cf.coef_square = ($urandom_range(0, 19) == 0) ? 32'd0 : any_coef();
			cf.coef_linear = any_coef();
			cf.coef_const  = ($urandom_range(0, 9) == 0) ? 32'd0 : any_coef();
			// bias toward real roots
			if ($urandom_range(0, 1) && cf.coef_square[31] == cf.coef_const[31])
				cf.coef_const = -cf.coef_const;
			coef_sets.push_back(cf);
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		wait (coef_sets.size() == 0 && roots_due.size() == 0);
		repeat (400) @(posedge clk);
		if (bad_count == 0 && roots_due.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2ms;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
